### hdl/ps2mct_pkg.sv
package ps2mct_pkg;

    localparam int DATA_W   = 8;
    localparam int CFG_IDX_W = 2;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_COLUMN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ROW    = 2'd2;

    localparam logic [DATA_W-1:0] STEP_SIZE_RST  = 8'd21;
    localparam logic [DATA_W-1:0] MAX_COLUMN_RST = 8'd79;
    localparam logic [DATA_W-1:0] MAX_ROW_RST    = 8'd24;

    // status byte bit positions
    localparam int ST_LEFT   = 0;
    localparam int ST_RIGHT  = 1;
    localparam int ST_MIDDLE = 2;
    localparam int ST_SYNC   = 3;
    localparam int ST_X_SIGN = 4;
    localparam int ST_Y_SIGN = 5;
    localparam int ST_X_OVF  = 6;
    localparam int ST_Y_OVF  = 7;

    // residue: ten bits signed; working position: eleven bits signed
    typedef logic signed [9:0]  residue_t;
    typedef logic signed [10:0] work_t;

endpackage

### hdl/ps2_mouse_cursor_tracker_core.sv
// ps2 mouse cursor tracker
// input channel: one mouse byte per request (data_byte, in_valid, in_stall).
// bytes are grouped as status, dx, dy. the first two bytes of a packet are
// taken without a stall. the third byte starts the movement sequencer and
// in_stall stays high until the result has been placed in the output register.
// a packet without the sync bit or with an overflow bit gives no result and
// is taken without a stall like any other byte.
// sequencer: one shared adder removes one step from the residue per cycle,
// first for x then for y. a valid packet keeps the input stalled from the
// third byte through the x load, the x steps, the y load, the y steps and
// the emit state.
// output channel: cursor_column, cursor_row and the three button bits with
// out_valid. the result register holds while out_stall is high; the
// sequencer waits in its last step for the register to free, so a stalled
// result also keeps the input stalled.
// configuration: cfg_valid, cfg_ready (always high), cfg_index, cfg_data;
// write only while idle.
// reset: position, residues and packet framing go to zero, registers to
// step 21, column limit 79, row limit 24.
module ps2_mouse_cursor_tracker_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [ps2mct_pkg::DATA_W-1:0]       data_byte,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [ps2mct_pkg::DATA_W-1:0]       cursor_column,
    output logic [ps2mct_pkg::DATA_W-1:0]       cursor_row,
    output logic                                left_pressed,
    output logic                                right_pressed,
    output logic                                middle_pressed,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ps2mct_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ps2mct_pkg::DATA_W-1:0]       cfg_data
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOAD_X = 3'd1;
    localparam logic [2:0] S_RUN_X  = 3'd2;
    localparam logic [2:0] S_LOAD_Y = 3'd3;
    localparam logic [2:0] S_RUN_Y  = 3'd4;
    localparam logic [2:0] S_EMIT   = 3'd5;

    localparam logic [1:0] BP_STATUS = 2'd0;
    localparam logic [1:0] BP_DX     = 2'd1;
    localparam logic [1:0] BP_DY     = 2'd2;

    logic [2:0] state_reg, state_next;
    logic [1:0] byte_pos_reg, byte_pos_next;
    logic [7:0] status_reg, status_next;
    logic [7:0] dx_reg, dx_next;
    logic [7:0] dy_reg, dy_next;
    ps2mct_pkg::residue_t x_res_reg, x_res_next;
    ps2mct_pkg::residue_t y_res_reg, y_res_next;
    logic [7:0] col_reg, col_next;
    logic [7:0] row_reg, row_next;
    ps2mct_pkg::residue_t work_res_reg, work_res_next;
    ps2mct_pkg::work_t    work_pos_reg, work_pos_next;
    logic [7:0] step_reg, step_next;
    logic [7:0] max_col_reg, max_col_next;
    logic [7:0] max_row_reg, max_row_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_col_reg, out_col_next;
    logic [7:0] out_row_reg, out_row_next;
    logic [2:0] out_btn_reg, out_btn_next;

    logic        in_take;
    logic        pkt_ok;
    logic [7:0]  step_eff;
    logic [7:0]  clamp_max;
    logic [7:0]  clamped;
    ps2mct_pkg::work_t step_ext;
    ps2mct_pkg::work_t res_ext;
    ps2mct_pkg::work_t add_a, add_b, add_sum;
    logic        res_neg;
    logic        over;
    logic        out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_take   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign pkt_ok = status_reg[ps2mct_pkg::ST_SYNC]
                    && !status_reg[ps2mct_pkg::ST_X_OVF]
                    && !status_reg[ps2mct_pkg::ST_Y_OVF];

    assign step_eff = (step_reg == 8'd0) ? 8'd1 : step_reg;
    assign step_ext = $signed({3'b000, step_eff});
    assign res_ext  = $signed({work_res_reg[9], work_res_reg});
    assign res_neg  = work_res_reg[9];
    assign over     = (res_ext > step_ext) || (res_ext < -step_ext);

    // shared adder: loads the residue with the delta, then takes steps off it
    always_comb
    begin
        unique case (state_reg)
            S_LOAD_X:
            begin
                add_a = $signed({x_res_reg[9], x_res_reg});
                add_b = $signed({{3{status_reg[ps2mct_pkg::ST_X_SIGN]}}, dx_reg});
            end
            S_LOAD_Y:
            begin
                add_a = $signed({y_res_reg[9], y_res_reg});
                add_b = $signed({{3{status_reg[ps2mct_pkg::ST_Y_SIGN]}}, dy_reg});
            end
            default:
            begin
                add_a = res_ext;
                add_b = res_neg ? step_ext : -step_ext;
            end
        endcase
        add_sum = add_a + add_b;
    end

    // saturate the working position to zero and to the axis limit
    always_comb
    begin
        clamp_max = (state_reg == S_RUN_X) ? max_col_reg : max_row_reg;
        if (work_pos_reg[10])
            clamped = 8'd0;
        else if (work_pos_reg[9:0] > {2'b00, clamp_max})
            clamped = clamp_max;
        else
            clamped = work_pos_reg[7:0];
    end

    always_comb
    begin
        state_next     = state_reg;
        byte_pos_next  = byte_pos_reg;
        status_next    = status_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        x_res_next     = x_res_reg;
        y_res_next     = y_res_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        work_res_next  = work_res_reg;
        work_pos_next  = work_pos_reg;
        step_next      = step_reg;
        max_col_next   = max_col_reg;
        max_row_next   = max_row_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        out_btn_next   = out_btn_reg;

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ps2mct_pkg::CFG_STEP_SIZE:  step_next    = cfg_data;
                ps2mct_pkg::CFG_MAX_COLUMN: max_col_next = cfg_data;
                ps2mct_pkg::CFG_MAX_ROW:    max_row_next = cfg_data;
                default:                    ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    unique case (byte_pos_reg)
                        BP_DX:
                        begin
                            dx_next       = data_byte;
                            byte_pos_next = BP_DY;
                        end
                        BP_DY:
                        begin
                            dy_next       = data_byte;
                            byte_pos_next = BP_STATUS;
                            if (pkt_ok)
                                state_next = S_LOAD_X;
                        end
                        default:
                        begin
                            status_next   = data_byte;
                            byte_pos_next = BP_DX;
                        end
                    endcase
                end
            end
            S_LOAD_X:
            begin
                work_res_next = add_sum[9:0];
                work_pos_next = $signed({3'b000, col_reg});
                state_next    = S_RUN_X;
            end
            S_RUN_X:
            begin
                if (over)
                begin
                    work_res_next = add_sum[9:0];
                    work_pos_next = res_neg ? work_pos_reg - 11'sd1
                                            : work_pos_reg + 11'sd1;
                end
                else
                begin
                    x_res_next = work_res_reg;
                    col_next   = clamped;
                    state_next = S_LOAD_Y;
                end
            end
            S_LOAD_Y:
            begin
                work_res_next = add_sum[9:0];
                work_pos_next = $signed({3'b000, row_reg});
                state_next    = S_RUN_Y;
            end
            S_RUN_Y:
            begin
                // positive y moves toward row zero
                if (over)
                begin
                    work_res_next = add_sum[9:0];
                    work_pos_next = res_neg ? work_pos_reg + 11'sd1
                                            : work_pos_reg - 11'sd1;
                end
                else
                begin
                    y_res_next = work_res_reg;
                    row_next   = clamped;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_col_next   = col_reg;
                    out_row_next   = row_reg;
                    out_btn_next   = {status_reg[ps2mct_pkg::ST_MIDDLE],
                                      status_reg[ps2mct_pkg::ST_RIGHT],
                                      status_reg[ps2mct_pkg::ST_LEFT]};
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            byte_pos_reg  <= BP_STATUS;
            status_reg    <= 8'd0;
            dx_reg        <= 8'd0;
            dy_reg        <= 8'd0;
            x_res_reg     <= '0;
            y_res_reg     <= '0;
            col_reg       <= 8'd0;
            row_reg       <= 8'd0;
            step_reg      <= ps2mct_pkg::STEP_SIZE_RST;
            max_col_reg   <= ps2mct_pkg::MAX_COLUMN_RST;
            max_row_reg   <= ps2mct_pkg::MAX_ROW_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            byte_pos_reg  <= byte_pos_next;
            status_reg    <= status_next;
            dx_reg        <= dx_next;
            dy_reg        <= dy_next;
            x_res_reg     <= x_res_next;
            y_res_reg     <= y_res_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            step_reg      <= step_next;
            max_col_reg   <= max_col_next;
            max_row_reg   <= max_row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_res_reg <= work_res_next;
        work_pos_reg <= work_pos_next;
        out_col_reg  <= out_col_next;
        out_row_reg  <= out_row_next;
        out_btn_reg  <= out_btn_next;
    end

    assign out_valid      = out_valid_reg;
    assign cursor_column  = out_col_reg;
    assign cursor_row     = out_row_reg;
    assign left_pressed   = out_btn_reg[0];
    assign right_pressed  = out_btn_reg[1];
    assign middle_pressed = out_btn_reg[2];

endmodule

### hdl/ps2mct_checker.sv
module ps2mct_checker
(
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_stall,
    input logic [ps2mct_pkg::DATA_W-1:0]       data_byte,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic [ps2mct_pkg::DATA_W-1:0]       cursor_column,
    input logic [ps2mct_pkg::DATA_W-1:0]       cursor_row,
    input logic                                left_pressed,
    input logic                                right_pressed,
    input logic                                middle_pressed
);

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(cursor_column)
            && $stable(cursor_row) && $stable(left_pressed)
            && $stable(right_pressed) && $stable(middle_pressed))
        else $error("result changed while stalled");

    // a stalled request holds its byte
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(data_byte))
        else $error("request changed while stalled");

    // the sequencer only starts on an accepted byte
    a_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(in_valid && !in_stall))
        else $error("input stalled without a request");

    // the sequencer only ends by handing over a result
    a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_stall) |-> out_valid)
        else $error("sequencer finished without a result");

    // a new result is only produced by the sequencer
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without sequencer work");

endmodule

bind ps2_mouse_cursor_tracker_core ps2mct_checker u_ps2mct_checker (.*);

### verif/ps2_mouse_cursor_tracker_checker.sv
`timescale 1ns / 100ps

module ps2_mouse_cursor_tracker_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic [ps2mct_pkg::DATA_W-1:0]       data_byte,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [ps2mct_pkg::DATA_W-1:0]       cursor_column,
    input  logic [ps2mct_pkg::DATA_W-1:0]       cursor_row,
    input  logic                                left_pressed,
    input  logic                                right_pressed,
    input  logic                                middle_pressed,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [ps2mct_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ps2mct_pkg::DATA_W-1:0]       cfg_data,
    input  logic                                run_over,
    output int                                  mismatches,
    output int                                  awaiting,
    output int                                  reports_checked,
    output int                                  packets_dropped
);

    typedef struct packed {
        logic [ps2mct_pkg::DATA_W-1:0] column;
        logic [ps2mct_pkg::DATA_W-1:0] row;
        logic                          left;
        logic                          right;
        logic                          middle;
    } cursor_report_t;

    cursor_report_t    expected_reports[$];

    logic [ps2mct_pkg::DATA_W-1:0] step_reg;
    logic [ps2mct_pkg::DATA_W-1:0] max_col_reg;
    logic [ps2mct_pkg::DATA_W-1:0] max_row_reg;

    logic [1:0]                    slot;
    logic [ps2mct_pkg::DATA_W-1:0] pkt_status;
    logic [ps2mct_pkg::DATA_W-1:0] dx_byte;
    ps2mct_pkg::residue_t          x_res;
    ps2mct_pkg::residue_t          y_res;
    logic [ps2mct_pkg::DATA_W-1:0] col_pos;
    logic [ps2mct_pkg::DATA_W-1:0] row_pos;
    logic                          leftovers_done;

    task automatic flag_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            flag_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    // removes whole steps while the residue is outside +/- step, returns cells moved
    function automatic int drain_steps(inout int acc, input int step);
        int cells;
        cells = 0;
        while (acc > step || acc < -step)
        begin
            if (acc < 0)
            begin
                acc += step;
                cells--;
            end
            else
            begin
                acc -= step;
                cells++;
            end
        end
        return cells;
    endfunction

    function automatic logic [ps2mct_pkg::DATA_W-1:0] clamp_cell(
        input int v, input logic [ps2mct_pkg::DATA_W-1:0] lim);
        if (v < 0)
            return '0;
        if (v > int'(lim))
            return lim;
        return v[ps2mct_pkg::DATA_W-1:0];
    endfunction

    task automatic take_mouse_byte(input logic [ps2mct_pkg::DATA_W-1:0] b);
        int             step;
        int             dx;
        int             dy;
        int             rx;
        int             ry;
        int             mx;
        int             my;
        cursor_report_t rep;
        case (slot)
            2'd1:
            begin
                dx_byte = b;
                slot    = 2'd2;
            end
            2'd2:
            begin
                slot = 2'd0;
                if (!pkt_status[ps2mct_pkg::ST_SYNC] || pkt_status[ps2mct_pkg::ST_X_OVF]
                    || pkt_status[ps2mct_pkg::ST_Y_OVF])
                    packets_dropped++;
                else
                begin
                    dx   = pkt_status[ps2mct_pkg::ST_X_SIGN] ? int'(dx_byte) - 256
                                                             : int'(dx_byte);
                    dy   = pkt_status[ps2mct_pkg::ST_Y_SIGN] ? int'(b) - 256 : int'(b);
                    step = (step_reg == 0) ? 1 : int'(step_reg);
                    rx   = int'(x_res) + dx;
                    ry   = int'(y_res) + dy;
                    mx   = drain_steps(rx, step);
                    my   = drain_steps(ry, step);
                    x_res = ps2mct_pkg::residue_t'(rx);
                    y_res = ps2mct_pkg::residue_t'(ry);
                    // positive y is upward, towards row zero
                    col_pos = clamp_cell(int'(col_pos) + mx, max_col_reg);
                    row_pos = clamp_cell(int'(row_pos) - my, max_row_reg);
                    rep.column = col_pos;
                    rep.row    = row_pos;
                    rep.left   = pkt_status[ps2mct_pkg::ST_LEFT];
                    rep.right  = pkt_status[ps2mct_pkg::ST_RIGHT];
                    rep.middle = pkt_status[ps2mct_pkg::ST_MIDDLE];
                    expected_reports.push_back(rep);
                end
            end
            default:
            begin
                pkt_status = b;
                slot       = 2'd1;
            end
        endcase
    endtask

    task automatic check_report();
        cursor_report_t want;
        if (expected_reports.size() == 0)
        begin
            flag_mismatch($sformatf("cursor report %0d/%0d with nothing expected",
                                    cursor_column, cursor_row));
            return;
        end
        want = expected_reports.pop_front();
        check_field("cursor_column", int'(cursor_column), int'(want.column));
        check_field("cursor_row", int'(cursor_row), int'(want.row));
        check_field("left_pressed", int'(left_pressed), int'(want.left));
        check_field("right_pressed", int'(right_pressed), int'(want.right));
        check_field("middle_pressed", int'(middle_pressed), int'(want.middle));
        reports_checked++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_reports.delete();
            step_reg        = ps2mct_pkg::STEP_SIZE_RST;
            max_col_reg     = ps2mct_pkg::MAX_COLUMN_RST;
            max_row_reg     = ps2mct_pkg::MAX_ROW_RST;
            slot            = 2'd0;
            pkt_status      = '0;
            dx_byte         = '0;
            x_res           = '0;
            y_res           = '0;
            col_pos         = '0;
            row_pos         = '0;
            mismatches      = 0;
            reports_checked = 0;
            packets_dropped = 0;
            leftovers_done  = 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_report();
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    ps2mct_pkg::CFG_STEP_SIZE:  step_reg    = cfg_data;
                    ps2mct_pkg::CFG_MAX_COLUMN: max_col_reg = cfg_data;
                    ps2mct_pkg::CFG_MAX_ROW:    max_row_reg = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                take_mouse_byte(data_byte);
            if (run_over && !leftovers_done)
            begin
                leftovers_done = 1'b1;
                foreach (expected_reports[i])
                    flag_mismatch($sformatf("expected cursor report %0d/%0d never came",
                                            expected_reports[i].column,
                                            expected_reports[i].row));
                expected_reports.delete();
            end
        end
        awaiting = expected_reports.size();
    end

endmodule

### verif/tb_ps2_mouse_cursor_tracker_core.sv
`timescale 1ns / 100ps

module tb_ps2_mouse_cursor_tracker_core;

    localparam int PHASES = 9;

    logic                                clk;
    logic                                rst_n;
    logic                                in_valid;
    logic                                in_stall;
    logic [ps2mct_pkg::DATA_W-1:0]       data_byte;
    logic                                out_valid;
    logic                                out_stall;
    logic [ps2mct_pkg::DATA_W-1:0]       cursor_column;
    logic [ps2mct_pkg::DATA_W-1:0]       cursor_row;
    logic                                left_pressed;
    logic                                right_pressed;
    logic                                middle_pressed;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [ps2mct_pkg::CFG_IDX_W-1:0]    cfg_index;
    logic [ps2mct_pkg::DATA_W-1:0]       cfg_data;
    logic                                run_over;

    int                   mismatches;
    int                   awaiting;
    int                   reports_checked;
    int                   packets_dropped;

    logic                 quiet;
    int                   gap_pct;
    int                   byte_slot;
    int                   bytes_sent;
    int                   settings_used;

    ps2_mouse_cursor_tracker_core DUT
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .cursor_column  (cursor_column),
        .cursor_row     (cursor_row),
        .left_pressed   (left_pressed),
        .right_pressed  (right_pressed),
        .middle_pressed (middle_pressed),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    ps2_mouse_cursor_tracker_checker u_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .data_byte       (data_byte),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .cursor_column   (cursor_column),
        .cursor_row      (cursor_row),
        .left_pressed    (left_pressed),
        .right_pressed   (right_pressed),
        .middle_pressed  (middle_pressed),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .run_over        (run_over),
        .mismatches      (mismatches),
        .awaiting        (awaiting),
        .reports_checked (reports_checked),
        .packets_dropped (packets_dropped)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // receiver back-pressure: calm stretches and short stall bursts
    initial
    begin : stall_gen
        int pick;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!quiet)
            begin
                pick = $urandom_range(0, 15);
                if (pick == 0)
                    repeat ($urandom_range(20, 80)) @(negedge clk);
                else if (pick < 6)
                begin
                    out_stall <= 1'b1;
                    repeat ($urandom_range(1, 6)) @(negedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    function automatic logic [ps2mct_pkg::DATA_W-1:0] rand_byte(input int lo, input int hi);
        int r;
        r = $urandom_range(lo, hi);
        return r[ps2mct_pkg::DATA_W-1:0];
    endfunction

    // in_valid stays high between back-to-back requests
    task automatic push_byte(input logic [ps2mct_pkg::DATA_W-1:0] b);
        int gap;
        gap = (!quiet && $urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 6) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        byte_slot  = (byte_slot == 2) ? 0 : byte_slot + 1;
        bytes_sent++;
    endtask

    task automatic push_packet(input logic [ps2mct_pkg::DATA_W-1:0] status,
                               input logic [ps2mct_pkg::DATA_W-1:0] dx,
                               input logic [ps2mct_pkg::DATA_W-1:0] dy);
        push_byte(status);
        push_byte(dx);
        push_byte(dy);
    endtask

    task automatic write_reg(input logic [ps2mct_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ps2mct_pkg::DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic apply_setting(input logic [ps2mct_pkg::DATA_W-1:0] step,
                                 input logic [ps2mct_pkg::DATA_W-1:0] col,
                                 input logic [ps2mct_pkg::DATA_W-1:0] row);
        @(negedge clk);
        in_valid <= 1'b0;
        while (awaiting != 0)
            @(negedge clk);
        // margin before the register writes
        repeat (16) @(posedge clk);
        write_reg(ps2mct_pkg::CFG_STEP_SIZE, step);
        write_reg(ps2mct_pkg::CFG_MAX_COLUMN, col);
        write_reg(ps2mct_pkg::CFG_MAX_ROW, row);
        @(negedge clk);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    initial
    begin : stimulus
        logic [ps2mct_pkg::DATA_W-1:0] step_tbl [PHASES];
        logic [ps2mct_pkg::DATA_W-1:0] col_tbl  [PHASES];
        logic [ps2mct_pkg::DATA_W-1:0] row_tbl  [PHASES];
        logic [ps2mct_pkg::DATA_W-1:0] status;
        int                            packets;
        int                            kind;
        int                            guard;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        data_byte     = '0;
        cfg_valid     = 1'b0;
        cfg_index     = ps2mct_pkg::CFG_STEP_SIZE;
        cfg_data      = '0;
        run_over      = 1'b0;
        quiet         = 1'b0;
        gap_pct       = 20;
        byte_slot     = 0;
        bytes_sent    = 0;
        settings_used = 1;

        step_tbl = '{8'd255, 8'd1, 8'd40, 8'd0, 8'd8, 8'd0, 8'd0, 8'd0, 8'd0};
        col_tbl  = '{8'd255, 8'd255, 8'd0, 8'd30, 8'd5, 8'd0, 8'd0, 8'd0, 8'd0};
        row_tbl  = '{8'd255, 8'd255, 8'd0, 8'd10, 8'd3, 8'd0, 8'd0, 8'd0, 8'd0};
        for (int p = 5; p < PHASES; p++)
        begin
            step_tbl[p] = rand_byte(2, 255);
            col_tbl[p]  = rand_byte(0, 255);
            row_tbl[p]  = rand_byte(0, 255);
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: buttons, full-scale deltas both ways, drops, edge saturation
        push_packet(8'h0F, 8'h00, 8'h00);
        push_packet(8'h08, 8'hFF, 8'h00);
        push_packet(8'h08, 8'h00, 8'hFF);
        push_packet(8'h38, 8'h00, 8'h00);
        push_packet(8'h00, 8'h55, 8'h55);
        push_packet(8'h48, 8'h10, 8'h10);
        push_packet(8'h88, 8'h10, 8'h10);
        push_packet(8'h0A, 8'h7F, 8'h80);

        for (int p = 0; p < PHASES; p++)
        begin
            apply_setting(step_tbl[p], col_tbl[p], row_tbl[p]);
            quiet   = (p == PHASES - 1);
            gap_pct = quiet ? 0 : $urandom_range(0, 2) * 20;
            while (byte_slot != 0)
                push_byte(rand_byte(0, 255));
            // still packet: pulls a position above a lowered limit back in
            push_packet(8'h08, 8'h00, 8'h00);
            packets = (step_tbl[p] <= 1) ? 16 : 62;
            for (int k = 0; k < packets; k++)
            begin
                kind   = $urandom_range(0, 9);
                status = rand_byte(0, 255);
                if (kind == 0)
                    push_byte(rand_byte(0, 255));
                else if (kind == 1)
                begin
                    case ($urandom_range(0, 2))
                        0: status[ps2mct_pkg::ST_SYNC] = 1'b0;
                        1: status[ps2mct_pkg::ST_X_OVF] = 1'b1;
                        default: status[ps2mct_pkg::ST_Y_OVF] = 1'b1;
                    endcase
                    push_packet(status, rand_byte(0, 255), rand_byte(0, 255));
                end
                else
                begin
                    status[ps2mct_pkg::ST_SYNC]  = 1'b1;
                    status[ps2mct_pkg::ST_X_OVF] = 1'b0;
                    status[ps2mct_pkg::ST_Y_OVF] = 1'b0;
                    push_packet(status, rand_byte(0, 255), rand_byte(0, 255));
                end
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        guard = 0;
        while (awaiting != 0 && guard < 200000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (16) @(posedge clk);
        @(negedge clk);
        run_over <= 1'b1;
        repeat (2) @(negedge clk);

        $display("sent %0d mouse bytes under %0d register settings", bytes_sent, settings_used);
        $display("%0d cursor reports compared, %0d packets dropped by framing checks",
                 reports_checked, packets_dropped);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
